FILE: rtl/tfbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbd_pkg
// Shared types, constants and digit-weight functions for the tilt frame
// BCD decoder.
// ----------------------------------------------------------------------------
package tfbd_pkg;

    // frame byte positions
    localparam logic [3:0] POS_HDR_LAST = 4'd3;
    localparam logic [3:0] POS_X_SIGN   = 4'd4;
    localparam logic [3:0] POS_X_HIGH   = 4'd5;
    localparam logic [3:0] POS_X_LOW    = 4'd6;
    localparam logic [3:0] POS_Y_SIGN   = 4'd7;
    localparam logic [3:0] POS_Y_HIGH   = 4'd8;
    localparam logic [3:0] POS_Y_LOW    = 4'd9;
    localparam logic [3:0] POS_IDLE     = 4'd10;

    localparam logic [7:0]  NEG_SIGN_BYTE = 8'h10;
    localparam logic [31:0] HEADER_RESET  = 32'h680D0084;

    // register byte offsets on the config port
    localparam logic [2:0] ADDR_HEADER = 3'd0;

    typedef logic [14:0] mag_t;

    // one decoded frame
    typedef struct packed {
        logic        header_ok;
        logic [15:0] x_angle;
        logic [15:0] y_angle;
    } result_t;

    // high digit pair in hundredths: hi*1000 + lo*100
    function automatic mag_t high_pair(input logic [7:0] b);
        logic [14:0] hi;
        logic [14:0] lo;
        begin
            hi = {11'd0, b[7:4]};
            lo = {11'd0, b[3:0]};
            high_pair = hi * 15'd1000 + lo * 15'd100;
        end
    endfunction

    // low digit pair in hundredths: hi*10 + lo
    function automatic mag_t low_pair(input logic [7:0] b);
        logic [14:0] hi;
        logic [14:0] lo;
        begin
            hi = {11'd0, b[7:4]};
            lo = {11'd0, b[3:0]};
            low_pair = hi * 15'd10 + lo;
        end
    endfunction

    // sign-magnitude to 16-bit two's complement
    function automatic logic [15:0] apply_sign(input logic neg, input mag_t mag);
        logic [15:0] m;
        begin
            m = {1'b0, mag};
            apply_sign = neg ? (16'd0 - m) : m;
        end
    endfunction

endpackage

FILE: rtl/tfbd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbd_cfg
// APB-style register file holding the expected four-byte frame header.
// ----------------------------------------------------------------------------
module tfbd_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] expected_header
);
    import tfbd_pkg::*;

    logic        hdr_sel;
    logic        wr_en;
    logic [31:0] header_reg;
    logic [31:0] header_next;

    // address decode on the register slot
    assign hdr_sel = (paddr[2] == ADDR_HEADER[2]);
    assign wr_en   = psel && penable && pwrite && hdr_sel;
    assign pready  = 1'b1;

    // next header value
    always_comb
    begin
        header_next = header_reg;
        if (wr_en)
        begin
            header_next = pwdata;
        end
    end

    // header register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
        end
        else
        begin
            header_reg <= header_next;
        end
    end

    // read back
    assign prdata          = hdr_sel ? header_reg : 32'd0;
    assign expected_header = header_reg;

endmodule

FILE: rtl/tfbd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbd_parser
// Tracks the byte position in a frame, checks the header and accumulates
// the packed-decimal X and Y magnitudes; emits one result when byte nine is accepted.
// ----------------------------------------------------------------------------
module tfbd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    input  logic [31:0]         expected_header,
    output logic                res_fire,
    output tfbd_pkg::result_t   res_data
);
    import tfbd_pkg::*;

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [3:0] pos_cur;
    logic       hdr_match_reg;
    logic       hdr_match_next;
    logic       x_neg_reg;
    logic       x_neg_next;
    mag_t       x_mag_reg;
    mag_t       x_mag_next;
    logic       y_neg_reg;
    logic       y_neg_next;
    mag_t       y_mag_reg;
    mag_t       y_mag_next;
    logic [7:0] want_byte;
    logic       byte_ok;
    logic       active;
    mag_t       y_mag_final;

    // position of this item, restarted by the frame flag
    assign pos_cur = frame_start ? 4'd0 : pos_reg;
    assign active  = accept && (pos_cur < POS_IDLE);

    // expected header byte, first byte in the top bits
    always_comb
    begin
        case (pos_cur[1:0])
            2'd0:    want_byte = expected_header[31:24];
            2'd1:    want_byte = expected_header[23:16];
            2'd2:    want_byte = expected_header[15:8];
            default: want_byte = expected_header[7:0];
        endcase
    end
    assign byte_ok = (rx_byte == want_byte);

    // per-position update
    always_comb
    begin
        pos_next       = pos_reg;
        hdr_match_next = hdr_match_reg;
        x_neg_next     = x_neg_reg;
        x_mag_next     = x_mag_reg;
        y_neg_next     = y_neg_reg;
        y_mag_next     = y_mag_reg;
        if (active)
        begin
            pos_next = pos_cur + 4'd1;
            if (pos_cur <= POS_HDR_LAST)
            begin
                hdr_match_next = (pos_cur == 4'd0) ? byte_ok : (hdr_match_reg & byte_ok);
            end
            else
            begin
                case (pos_cur)
                    POS_X_SIGN: x_neg_next = (rx_byte == NEG_SIGN_BYTE);
                    POS_X_HIGH: x_mag_next = high_pair(rx_byte);
                    POS_X_LOW:  x_mag_next = x_mag_reg + low_pair(rx_byte);
                    POS_Y_SIGN: y_neg_next = (rx_byte == NEG_SIGN_BYTE);
                    POS_Y_HIGH: y_mag_next = high_pair(rx_byte);
                    default:    y_mag_next = y_mag_final;
                endcase
            end
        end
        else if (accept && frame_start)
        begin
            pos_next = pos_cur;
        end
    end

    // final Y magnitude and the result
    assign y_mag_final        = y_mag_reg + low_pair(rx_byte);
    assign res_fire           = active && (pos_cur == POS_Y_LOW);
    assign res_data.header_ok = hdr_match_reg;
    assign res_data.x_angle   = apply_sign(x_neg_reg, x_mag_reg);
    assign res_data.y_angle   = apply_sign(y_neg_reg, y_mag_final);

    // position counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_IDLE;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // frame fields
    always_ff @(posedge clk)
    begin
        hdr_match_reg <= hdr_match_next;
        x_neg_reg     <= x_neg_next;
        x_mag_reg     <= x_mag_next;
        y_neg_reg     <= y_neg_next;
        y_mag_reg     <= y_mag_next;
    end

    // position never passes idle
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_IDLE)
        else $error("byte position out of range");

    // a result closes the frame
    a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |=> pos_reg == POS_IDLE)
        else $error("position not idle after result");

    // idle holds until a frame start
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_IDLE && !(accept && frame_start)) |=> pos_reg == POS_IDLE)
        else $error("left idle without frame start");

endmodule

FILE: rtl/tfbd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbd_out_reg
// Result register between the decoder and the output channel.
// ----------------------------------------------------------------------------
module tfbd_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tfbd_pkg::result_t   load_data,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                full_stalled,
    output tfbd_pkg::result_t   out_data
);
    import tfbd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    assign full_stalled = valid_reg && out_stall;

    // hold while stalled, otherwise load or drain
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (!full_stalled)
        begin
            valid_next = load;
            if (load)
            begin
                data_next = load_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // never overwrite a held item
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(load && full_stalled))
        else $error("result loaded while output held");

endmodule

FILE: rtl/tilt_frame_bcd_decoder_top.sv
`timescale 1ns / 1ps
// A result is registered onto out_valid in the cycle after byte nine of a frame is accepted.
// Throughput: one byte per cycle; in_stall rises only while a result waits under out_stall.
// Each byte is decoded in one pass of logic between the frame-state and result registers.
// Reset: decoder idles until a frame start, no result pending, header = 0x680D0084.
// ----------------------------------------------------------------------------
// tilt_frame_bcd_decoder_top
// Decodes inclinometer reply frames into header match and X/Y angles.
// ----------------------------------------------------------------------------
module tilt_frame_bcd_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        header_ok,
    output logic signed [15:0] x_angle_centideg,
    output logic signed [15:0] y_angle_centideg
);
    import tfbd_pkg::*;

    logic [31:0] expected_header;
    logic        in_accept;
    logic        res_fire;
    logic        full_stalled;
    result_t     res_data;
    result_t     out_data;

    // config registers
    tfbd_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .expected_header (expected_header)
    );

    // input handshake
    assign in_stall  = full_stalled;
    assign in_accept = in_valid && !in_stall;

    // frame decode
    tfbd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_accept),
        .rx_byte         (rx_byte),
        .frame_start     (frame_start),
        .expected_header (expected_header),
        .res_fire        (res_fire),
        .res_data        (res_data)
    );

    // result register
    tfbd_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_fire),
        .load_data    (res_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .full_stalled (full_stalled),
        .out_data     (out_data)
    );

    assign header_ok        = out_data.header_ok;
    assign x_angle_centideg = out_data.x_angle;
    assign y_angle_centideg = out_data.y_angle;

endmodule

FILE: dv/tilt_frame_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_frame_scoreboard_pkg
// Frame decode predictor and result scoreboard for the tilt frame BCD
// decoder bench. Every accepted byte goes through a local copy of the
// decoder state, and each completed frame queues one expected result.
// ----------------------------------------------------------------------------
package tilt_frame_scoreboard_pkg;

    import tfbd_pkg::*;

    class frame_scoreboard;

        // local copy of the header register and the decode state
        logic [31:0] header_cfg;
        logic [3:0]  pos;
        logic        hdr_match;
        logic        x_neg;
        logic [14:0] x_mag;
        logic        y_neg;
        logic [14:0] y_mag;

        result_t     frame_q[$];
        int          mismatch_count;

        function new();
            header_cfg     = HEADER_RESET;
            pos            = POS_IDLE;
            hdr_match      = 1'b1;
            x_neg          = 1'b0;
            x_mag          = '0;
            y_neg          = 1'b0;
            y_mag          = '0;
            mismatch_count = 0;
        endfunction

        // tens and units of degrees, in hundredths; nibbles above nine kept as is
        function logic [14:0] whole_centi(logic [7:0] b);
            int unsigned v;
            v = int'(b[7:4]) * 1000 + int'(b[3:0]) * 100;
            return v[14:0];
        endfunction

        // tenths and hundredths of a degree
        function logic [14:0] frac_centi(logic [7:0] b);
            int unsigned v;
            v = int'(b[7:4]) * 10 + int'(b[3:0]);
            return v[14:0];
        endfunction

        function logic [15:0] signed_centi(logic neg, logic [14:0] mag);
            logic [15:0] m;
            m = {1'b0, mag};
            return neg ? 16'(-m) : m;
        endfunction

        function int pending();
            return frame_q.size();
        endfunction

        task flag_mismatch(string what);
            mismatch_count++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // advance the decode state by one accepted item
        function void note_byte(logic [7:0] b, logic start);
            int      idx;
            logic    hit;
            result_t r;
            if (start)
                pos = 4'd0;
            if (pos >= POS_IDLE)
                return;
            idx = int'(pos);
            if (pos <= POS_HDR_LAST)
            begin
                hit       = (b == header_cfg[31 - 8 * idx -: 8]);
                hdr_match = (idx == 0) ? hit : (hdr_match & hit);
            end
            else
            begin
                case (pos)
                    POS_X_SIGN: x_neg = (b == NEG_SIGN_BYTE);
                    POS_X_HIGH: x_mag = whole_centi(b);
                    POS_X_LOW:  x_mag = x_mag + frac_centi(b);
                    POS_Y_SIGN: y_neg = (b == NEG_SIGN_BYTE);
                    POS_Y_HIGH: y_mag = whole_centi(b);
                    default:    y_mag = y_mag + frac_centi(b);
                endcase
            end
            if (pos == POS_Y_LOW)
            begin
                r.header_ok = hdr_match;
                r.x_angle   = signed_centi(x_neg, x_mag);
                r.y_angle   = signed_centi(y_neg, y_mag);
                frame_q.push_back(r);
            end
            pos = pos + 4'd1;
        endfunction

        // compare one decoded frame against the oldest expectation
        task check_frame(logic hok, logic [15:0] xa, logic [15:0] ya);
            result_t e;
            if (frame_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected frame hdr=%0b x=%0d y=%0d",
                                        hok, $signed(xa), $signed(ya)));
                return;
            end
            e = frame_q.pop_front();
            if (hok !== e.header_ok)
                flag_mismatch($sformatf("header_ok got %0b want %0b", hok, e.header_ok));
            if (xa !== e.x_angle)
                flag_mismatch($sformatf("x angle got %0d want %0d",
                                        $signed(xa), $signed(e.x_angle)));
            if (ya !== e.y_angle)
                flag_mismatch($sformatf("y angle got %0d want %0d",
                                        $signed(ya), $signed(e.y_angle)));
        endtask

    endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt frame BCD decoder. Sends directed and
// random inclinometer frames under random source gaps and sink stalls,
// rewrites the header register between phases, and checks every decoded
// frame against the scoreboard's own decode of the accepted bytes.
// ----------------------------------------------------------------------------
module tb_top;

    import tfbd_pkg::*;
    import tilt_frame_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int PHASE_BYTES  = 175;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 4;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               frame_start;
    logic               out_valid;
    logic               out_stall;
    logic               header_ok;
    logic signed [15:0] x_angle_centideg;
    logic signed [15:0] y_angle_centideg;

    frame_scoreboard sb;
    int  cycle_count;
    int  frame_bytes;
    bit  idle_on;
    bit  hold_req;

    tilt_frame_bcd_decoder_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .frame_start      (frame_start),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .header_ok        (header_ok),
        .x_angle_centideg (x_angle_centideg),
        .y_angle_centideg (y_angle_centideg)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_frame(header_ok, x_angle_centideg, y_angle_centideg);
    end

    // sink stalls: random short bursts plus one long hold on request
    initial
    begin
        int burst;
        int hold;
        burst = 0;
        hold  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold     = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 7) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic int pick_gap();
        if (idle_on && $urandom_range(0, 4) == 0)
            return $urandom_range(1, 7);
        return 0;
    endfunction

    // offer one item, called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= s;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b, s);
        @(negedge clk);
    endtask

    // stop offering and wait until every decoded frame has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_header(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_HEADER;
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.header_cfg = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        // read back
        psel    <= 1'b1;
        paddr   <= ADDR_HEADER;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== sb.header_cfg)
            sb.flag_mismatch($sformatf("header readback got %h want %h",
                                       prdata, sb.header_cfg));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] sign_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return NEG_SIGN_BYTE;
        if (r < 75)
            return 8'h00;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] digit_byte();
        if ($urandom_range(0, 9) < 7)
            return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        return 8'($urandom);
    endfunction

    // one random frame: mostly well formed, some bad headers, short frames
    // and trailing bytes that the decoder should ignore
    task automatic send_frame();
        logic [7:0] fb [0:9];
        int kind;
        int n;
        int i;
        kind = $urandom_range(0, 99);
        for (i = 0; i < 4; i++)
            fb[i] = sb.header_cfg[31 - 8 * i -: 8];
        if (kind < 15)
            fb[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        else if (kind < 20)
            for (i = 0; i < 4; i++)
                fb[i] = 8'($urandom);
        fb[4] = sign_byte();
        fb[5] = digit_byte();
        fb[6] = digit_byte();
        fb[7] = sign_byte();
        fb[8] = digit_byte();
        fb[9] = digit_byte();
        n = 10;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(1, 9);
        for (i = 0; i < n; i++)
            send_byte(fb[i], i == 0);
        frame_bytes += n;
        if (n == 10 && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    // main sequence
    initial
    begin
        logic [31:0] hdr_list [0:4];
        int ph;
        sb          = new();
        cycle_count = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        rx_byte     <= '0;
        frame_start <= 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bytes before any frame start are dropped
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // reset header, X negative with all nibbles above nine, Y negative zero
        send_byte(8'h68, 1'b1);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h84, 1'b0);
        send_byte(NEG_SIGN_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(NEG_SIGN_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // byte after byte nine is ignored
        send_byte(8'h10, 1'b0);
        // short frame dropped by the next frame start
        send_byte(8'h68, 1'b1);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h00, 1'b0);
        // last header byte off, odd X sign byte read as positive
        send_byte(8'h68, 1'b1);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h85, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h99, 1'b0);
        send_byte(8'h99, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        drain();

        // random phases, each under its own header setting
        hdr_list[0] = 32'h0000_0000;
        hdr_list[1] = 32'hFFFF_FFFF;
        hdr_list[2] = $urandom;
        hdr_list[3] = $urandom;
        hdr_list[4] = HEADER_RESET;
        for (ph = 0; ph < 5; ph++)
        begin
            write_header(hdr_list[ph]);
            idle_on = (ph < 3);
            if (ph == 1)
                hold_req = 1'b1;
            frame_bytes = 0;
            while (frame_bytes < PHASE_BYTES)
                send_frame();
            drain();
        end

        if (sb.mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
